// File: sv/tlvd_pkg.sv
// Shared types and codes for the TLV stream deframer.
// No dependencies.
package tlvd_pkg;

	typedef logic [2:0] event_t;
	typedef logic [2:0] phase_t;

	localparam event_t EV_HDR   = 3'd0;
	localparam event_t EV_HDONE = 3'd1;
	localparam event_t EV_VALUE = 3'd2;
	localparam event_t EV_ERR   = 3'd3;
	localparam event_t EV_IGN   = 3'd4;

	localparam phase_t PH_TYPE_FIRST = 3'd0;
	localparam phase_t PH_TYPE_EXT   = 3'd1;
	localparam phase_t PH_LEN_FIRST  = 3'd2;
	localparam phase_t PH_LEN_EXT    = 3'd3;
	localparam phase_t PH_VALUE      = 3'd4;
	localparam phase_t PH_ERROR      = 3'd5;

	localparam logic [7:0] MARK_WORD  = 8'd253;
	localparam logic [7:0] MARK_DWORD = 8'd254;

	localparam logic [2:0] EXT_WORD  = 3'd2;
	localparam logic [2:0] EXT_DWORD = 3'd4;

endpackage

// File: sv/tlv_stream_deframer.sv
// TLV stream deframer: top level, input register, per-byte decode and result register.
// Depends on tlvd_pkg.
//
// Takes one byte per item and gives one result item for each, in order. A new
// byte can be taken while the last one is decoded, unless the output stalls: a
// byte sits in the input register while the combinational decode updates the
// record state and loads the result register, so throughput is one item per
// clock while out_ready holds, and the result comes out of the result register,
// which follows the input register. The rate is set by the decode state update.
// Type and length are variable numbers (one byte below 253, 253 plus two bytes,
// 254 plus four); a bad header or an over-long length reports an error and the
// rest of the buffer comes out as ignored items. A start flag always restarts decoding.
module tlv_stream_deframer #(
	parameter int BUFFER_COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                buffer_start,
	input  logic [15:0]         buffer_length,
	output logic                out_valid,
	input  logic                out_ready,
	output tlvd_pkg::event_t    event_res,
	output logic [31:0]         record_type,
	output logic [31:0]         record_length,
	output logic [7:0]          value_out,
	output logic                value_done,
	output logic [63:0]         value_number,
	output logic                buffer_done
);
	import tlvd_pkg::*;

	localparam int CW = BUFFER_COUNT_BITS;

	// input register
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          start_s1;
	logic [15:0]   len_s1;

	// decode state
	phase_t        phase_q;
	logic [2:0]    extra_q;
	logic [31:0]   num_acc_q;
	logic [31:0]   cur_type_q;
	logic [31:0]   cur_len_q;
	logic [31:0]   val_left_q;
	logic [CW-1:0] buf_left_q;
	logic [63:0]   val_acc_q;

	// result register
	logic          out_valid_q;
	event_t        ev_q;
	logic [31:0]   type_q;
	logic [31:0]   len_q;
	logic [7:0]    vout_q;
	logic          vdone_q;
	logic [63:0]   vnum_q;
	logic          bdone_q;

	logic advance;
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// next-state and result values
	phase_t        n_phase;
	logic [2:0]    n_extra;
	logic [31:0]   n_num_acc;
	logic [31:0]   n_cur_type;
	logic [31:0]   n_cur_len;
	logic [31:0]   n_val_left;
	logic [CW-1:0] n_buf_left;
	logic [63:0]   n_val_acc;
	event_t        r_ev;
	logic [7:0]    r_vout;
	logic          r_vdone;
	logic          r_bdone;

	always_comb begin
		logic [CW-1:0] rem;
		logic [31:0]   rem32;
		logic [31:0]   v;
		logic [31:0]   acc_sh;
		logic [2:0]    ext_dec;
		logic          type_done;
		logic          len_done;
		logic          first_err;
		logic          first_more;
		logic [2:0]    first_ext;

		n_phase    = phase_q;
		n_extra    = extra_q;
		n_num_acc  = num_acc_q;
		n_cur_type = cur_type_q;
		n_cur_len  = cur_len_q;
		n_val_left = val_left_q;
		n_buf_left = buf_left_q;
		n_val_acc  = val_acc_q;
		r_ev       = EV_HDR;
		r_vout     = 8'd0;
		r_vdone    = 1'b0;
		r_bdone    = 1'b0;
		type_done  = 1'b0;
		len_done   = 1'b0;
		v          = 32'd0;

		if (start_s1) begin
			n_buf_left = CW'(len_s1);
			n_phase    = PH_TYPE_FIRST;
		end

		rem   = n_buf_left - CW'(1);
		rem32 = 32'(rem);

		// first byte of a variable number
		first_err  = 1'b0;
		first_more = 1'b0;
		first_ext  = EXT_WORD;
		if (byte_s1 == MARK_WORD && rem >= CW'(2)) begin
			first_more = 1'b1;
			first_ext  = EXT_WORD;
		end else if (byte_s1 == MARK_DWORD && rem >= CW'(4)) begin
			first_more = 1'b1;
			first_ext  = EXT_DWORD;
		end else if (byte_s1 >= MARK_WORD) begin
			first_err = 1'b1;
		end

		acc_sh  = {num_acc_q[23:0], byte_s1};
		ext_dec = extra_q - 3'd1;

		if (n_buf_left == '0) begin
			r_ev = EV_IGN;
		end else begin
			n_buf_left = rem;
			case (n_phase)
				PH_TYPE_FIRST: begin
					n_cur_type = 32'd0;
					n_cur_len  = 32'd0;
					n_val_acc  = 64'd0;
					if (first_err) begin
						r_ev = EV_ERR;
					end else if (first_more) begin
						n_extra   = first_ext;
						n_num_acc = 32'd0;
						n_phase   = PH_TYPE_EXT;
					end else begin
						v         = {24'd0, byte_s1};
						type_done = 1'b1;
					end
				end
				PH_TYPE_EXT: begin
					n_num_acc = acc_sh;
					n_extra   = ext_dec;
					if (ext_dec == 3'd0) begin
						v         = acc_sh;
						type_done = 1'b1;
					end
				end
				PH_LEN_FIRST: begin
					if (first_err) begin
						r_ev = EV_ERR;
					end else if (first_more) begin
						n_extra   = first_ext;
						n_num_acc = 32'd0;
						n_phase   = PH_LEN_EXT;
					end else begin
						v        = {24'd0, byte_s1};
						len_done = 1'b1;
					end
				end
				PH_LEN_EXT: begin
					n_num_acc = acc_sh;
					n_extra   = ext_dec;
					if (ext_dec == 3'd0) begin
						v        = acc_sh;
						len_done = 1'b1;
					end
				end
				PH_VALUE: begin
					r_ev       = EV_VALUE;
					r_vout     = byte_s1;
					n_val_acc  = {val_acc_q[55:0], byte_s1};
					n_val_left = val_left_q - 32'd1;
					if (n_val_left == 32'd0) begin
						r_vdone = 1'b1;
						n_phase = PH_TYPE_FIRST;
						r_bdone = (rem == '0);
					end
				end
				default: begin
					r_ev = EV_IGN;
				end
			endcase

			if (type_done) begin
				n_cur_type = v;
				n_phase    = PH_LEN_FIRST;
				if (rem == '0) begin
					r_ev = EV_ERR;
				end
			end
			if (len_done) begin
				if (v > rem32) begin
					r_ev = EV_ERR;
				end else begin
					r_ev       = EV_HDONE;
					n_cur_len  = v;
					n_val_left = v;
					n_val_acc  = 64'd0;
					if (v == 32'd0) begin
						r_vdone = 1'b1;
						n_phase = PH_TYPE_FIRST;
						r_bdone = (rem == '0);
					end else begin
						n_phase = PH_VALUE;
					end
				end
			end
			if (r_ev == EV_ERR) begin
				n_phase = PH_ERROR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= data_byte;
			start_s1 <= buffer_start;
			len_s1   <= buffer_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TYPE_FIRST;
			extra_q    <= 3'd0;
			num_acc_q  <= 32'd0;
			cur_type_q <= 32'd0;
			cur_len_q  <= 32'd0;
			val_left_q <= 32'd0;
			buf_left_q <= '0;
			val_acc_q  <= 64'd0;
		end else if (advance) begin
			phase_q    <= n_phase;
			extra_q    <= n_extra;
			num_acc_q  <= n_num_acc;
			cur_type_q <= n_cur_type;
			cur_len_q  <= n_cur_len;
			val_left_q <= n_val_left;
			buf_left_q <= n_buf_left;
			val_acc_q  <= n_val_acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// error and ignored items carry zeros in every field but the event code
	always_ff @(posedge clk) begin
		if (advance) begin
			ev_q <= r_ev;
			if (r_ev == EV_ERR || r_ev == EV_IGN) begin
				type_q  <= 32'd0;
				len_q   <= 32'd0;
				vout_q  <= 8'd0;
				vdone_q <= 1'b0;
				vnum_q  <= 64'd0;
				bdone_q <= 1'b0;
			end else begin
				type_q  <= n_cur_type;
				len_q   <= n_cur_len;
				vout_q  <= r_vout;
				vdone_q <= r_vdone;
				vnum_q  <= n_val_acc;
				bdone_q <= r_bdone;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign event_res     = ev_q;
	assign record_type   = type_q;
	assign record_length = len_q;
	assign value_out     = vout_q;
	assign value_done    = vdone_q;
	assign value_number  = vnum_q;
	assign buffer_done   = bdone_q;

endmodule
